[design/hmrd_pkg.sv]
// Package for the histogram mean relative deviation unit: widths, register
// indexes, queue item and window types, saturation helpers. No dependencies.
package hmrd_pkg;

  localparam int VALUE_BITS    = 32;
  localparam int FRACTION_BITS = 16;
  localparam int IDX_BITS      = 10;
  localparam int COUNT_BITS    = 21;
  localparam int SUM_BITS      = 52;
  localparam int DEV_BITS      = 32;
  localparam int DIFF_BITS     = VALUE_BITS + 1;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [COUNT_BITS-1:0] MAX_BINS = COUNT_BITS'(1048576);

  localparam int DIV_STEPS     = SUM_BITS;
  localparam int STEP_BITS     = $clog2(DIV_STEPS);

  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD   = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_X_FIRST_BIN = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_X_LAST_BIN  = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_FIRST_BIN = CFG_IDX_BITS'(3);
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_LAST_BIN  = CFG_IDX_BITS'(4);

  typedef struct packed {
    logic [IDX_BITS-1:0] x_first;
    logic [IDX_BITS-1:0] x_last;
    logic [IDX_BITS-1:0] y_first;
    logic [IDX_BITS-1:0] y_last;
  } hmrd_win_t;

  typedef struct packed {
    logic [DIFF_BITS-1:0]  diff;
    logic [VALUE_BITS-1:0] aref;
    logic                  count_it;
    logic                  last;
  } hmrd_item_t;

  function automatic logic [DEV_BITS-1:0] sat_dev(input logic [SUM_BITS-1:0] q);
    logic [DEV_BITS-1:0] r;
    r = (|q[SUM_BITS-1:DEV_BITS]) ? '1 : q[DEV_BITS-1:0];
    return r;
  endfunction

  function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] s,
                                                  input logic [DEV_BITS-1:0] d);
    logic [SUM_BITS:0] t;
    t = {1'b0, s} + {(SUM_BITS - DEV_BITS + 1)'(0), d};
    return t[SUM_BITS] ? '1 : t[SUM_BITS-1:0];
  endfunction

endpackage

[design/hmrd_if.sv]
// Channel interfaces of the histogram mean relative deviation unit:
// input bin pairs, results and configuration writes. Depends on hmrd_pkg.
interface hmrd_in_if import hmrd_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] bin_value;
  logic signed [VALUE_BITS-1:0] reference_value;
  logic [IDX_BITS-1:0]          bin_x;
  logic [IDX_BITS-1:0]          bin_y;
  logic                         last_bin;
  modport source (output valid, bin_value, reference_value, bin_x, bin_y, last_bin,
                  input ready);
  modport sink (input valid, bin_value, reference_value, bin_x, bin_y, last_bin,
                output ready);
endinterface

interface hmrd_out_if import hmrd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  quality;
  logic [DEV_BITS-1:0]   mean_deviation;
  logic [COUNT_BITS-1:0] bins_counted;
  modport source (output valid, quality, mean_deviation, bins_counted, input ready);
  modport sink (input valid, quality, mean_deviation, bins_counted, output ready);
endinterface

interface hmrd_cfg_if import hmrd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/histogram_mean_relative_deviation_unit.sv]
// Histogram mean relative deviation unit: configuration registers, front end,
// queue and back end. Depends on hmrd_pkg, hmrd_if, hmrd_front, hmrd_queue, hmrd_back.
//
// Usage: in_ch carries one bin pair per transaction (measured value, reference
// value, x/y bin index, last flag). Bins inside the x/y window add
// |val-ref|/|ref| (Q16.16, saturated) to a running sum; the transaction with
// last_bin set closes the histogram and yields one out_ch transaction with the
// verdict, the mean deviation and the bin count. cfg_ch writes the threshold
// and window registers (indexes 0..4); it is always ready. The user must write it
// only while the block is idle; the block itself does not enforce this.
// Timing: the front end takes a bin every cycle while the four-entry queue
// has room. The back end pops one item per cycle unless the bin is counted
// with a nonzero reference, which then goes through the serial divider, or
// closes the histogram: with counted bins the mean division runs in the
// divider, then the result register is loaded.
// Reset clears the queue, sum, count and result valid and loads the register
// defaults. If out_ch stalls, the result is held in its register; the queue
// keeps accepting bins until full, then in_ch.ready drops.
module histogram_mean_relative_deviation_unit import hmrd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  hmrd_in_if.sink    in_ch,
  hmrd_out_if.source out_ch,
  hmrd_cfg_if.sink   cfg_ch
);

  logic [DEV_BITS-1:0] threshold_r;
  hmrd_win_t           win_r;
  logic                q_push, q_full, q_pop, q_valid;
  hmrd_item_t          q_in, q_out;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r   <= DEV_BITS'(65536);
      win_r.x_first <= '0;
      win_r.x_last  <= '1;
      win_r.y_first <= '0;
      win_r.y_last  <= '1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_THRESHOLD:   threshold_r   <= cfg_ch.data[DEV_BITS-1:0];
        REG_X_FIRST_BIN: win_r.x_first <= cfg_ch.data[IDX_BITS-1:0];
        REG_X_LAST_BIN:  win_r.x_last  <= cfg_ch.data[IDX_BITS-1:0];
        REG_Y_FIRST_BIN: win_r.y_first <= cfg_ch.data[IDX_BITS-1:0];
        REG_Y_LAST_BIN:  win_r.y_last  <= cfg_ch.data[IDX_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  hmrd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .win    (win_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_in)
  );

  hmrd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_out)
  );

  hmrd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_out),
    .q_pop     (q_pop),
    .threshold (threshold_r),
    .out_ch    (out_ch)
  );

endmodule

[design/hmrd_front.sv]
// Front end: accepts bin pairs, applies the window and the bin limit, forms
// |val-ref| and |ref| and pushes one queue item. Depends on hmrd_pkg, hmrd_if.
module hmrd_front import hmrd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  hmrd_in_if.sink      in_ch,
  input  hmrd_win_t    win,
  input  logic         q_full,
  output logic         q_push,
  output hmrd_item_t   q_item
);

  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  in_win;
  logic                  count_it;
  logic                  accept;
  logic signed [DIFF_BITS-1:0] d;
  logic [DIFF_BITS-1:0]  diff;
  logic [VALUE_BITS-1:0] aref;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  assign in_win = (in_ch.bin_x >= win.x_first) && (in_ch.bin_x <= win.x_last) &&
                  (in_ch.bin_y >= win.y_first) && (in_ch.bin_y <= win.y_last);
  assign count_it = in_win && (cnt_r < MAX_BINS);

  assign d    = {in_ch.bin_value[VALUE_BITS-1], in_ch.bin_value} -
                {in_ch.reference_value[VALUE_BITS-1], in_ch.reference_value};
  assign diff = d[DIFF_BITS-1] ? DIFF_BITS'(-d) : DIFF_BITS'(d);
  assign aref = in_ch.reference_value[VALUE_BITS-1] ?
                VALUE_BITS'(-in_ch.reference_value) : VALUE_BITS'(in_ch.reference_value);

  assign q_push          = accept;
  assign q_item.diff     = diff;
  assign q_item.aref     = aref;
  assign q_item.count_it = count_it;
  assign q_item.last     = in_ch.last_bin;

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_ch.last_bin) begin
        cnt_nxt = '0;
      end else if (count_it) begin
        cnt_nxt = cnt_r + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[design/hmrd_queue.sv]
// Short queue between front and back end, holding classified bin items.
// Depends on hmrd_pkg.
module hmrd_queue import hmrd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  hmrd_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       pop_valid,
  output hmrd_item_t pop_item
);

  hmrd_item_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_BITS:0]   fill_r, fill_nxt;
  logic                 do_push, do_pop;

  assign full      = (fill_r == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign pop_valid = (fill_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    fill_nxt = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + (QPTR_BITS+1)'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - (QPTR_BITS+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[design/hmrd_back.sv]
// Back end: shared one-bit-per-cycle divider for the per-bin ratio and the
// final mean, running sum and count, result register. Depends on hmrd_pkg, hmrd_if.
module hmrd_back import hmrd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  hmrd_item_t           q_item,
  output logic                 q_pop,
  input  logic [DEV_BITS-1:0]  threshold,
  hmrd_out_if.source           out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DEV  = 2'd1;
  localparam logic [1:0] ST_MEAN = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic                  last_r, last_nxt;
  logic [SUM_BITS-1:0]   sum_r, sum_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] dvs_r, dvs_nxt;
  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [SUM_BITS-1:0]   quo_r, quo_nxt;
  logic [STEP_BITS-1:0]  step_r, step_nxt;
  logic [DEV_BITS-1:0]   mean_r, mean_nxt;

  logic                  ov_r, ov_nxt;
  logic                  oq_r, oq_nxt;
  logic [DEV_BITS-1:0]   om_r, om_nxt;
  logic [COUNT_BITS-1:0] oc_r, oc_nxt;

  logic [VALUE_BITS:0]   rem_sh, rem_sub;
  logic                  ge;
  logic [SUM_BITS-1:0]   q_fin;
  logic                  div_done;

  assign rem_sh   = {rem_r, quo_r[SUM_BITS-1]};
  assign rem_sub  = rem_sh - {1'b0, dvs_r};
  assign ge       = (rem_sh >= {1'b0, dvs_r});
  assign q_fin    = {quo_r[SUM_BITS-2:0], ge};
  assign div_done = (step_r == STEP_BITS'(DIV_STEPS - 1));

  assign out_ch.valid          = ov_r;
  assign out_ch.quality        = oq_r;
  assign out_ch.mean_deviation = om_r;
  assign out_ch.bins_counted   = oc_r;

  always_comb begin
    logic                  fin;
    logic                  last_v;
    logic [COUNT_BITS-1:0] cnt_v;
    logic [SUM_BITS-1:0]   sum_v;

    fin       = 1'b0;
    last_v    = last_r;
    cnt_v     = cnt_r;
    sum_v     = sum_r;
    state_nxt = state_r;
    last_nxt  = last_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    dvs_nxt   = dvs_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    step_nxt  = step_r;
    mean_nxt  = mean_r;
    q_pop     = 1'b0;
    ov_nxt    = ov_r && !out_ch.ready;
    oq_nxt    = oq_r;
    om_nxt    = om_r;
    oc_nxt    = oc_r;

    if (state_r == ST_DEV || state_r == ST_MEAN) begin
      rem_nxt  = ge ? rem_sub[VALUE_BITS-1:0] : rem_sh[VALUE_BITS-1:0];
      quo_nxt  = q_fin;
      step_nxt = step_r + STEP_BITS'(1);
    end

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          last_nxt = q_item.last;
          last_v   = q_item.last;
          if (q_item.count_it) begin
            cnt_nxt = cnt_r + COUNT_BITS'(1);
            cnt_v   = cnt_r + COUNT_BITS'(1);
          end
          if (q_item.count_it && (q_item.aref != '0)) begin
            dvs_nxt   = q_item.aref;
            rem_nxt   = '0;
            quo_nxt   = {(SUM_BITS - DIFF_BITS - FRACTION_BITS)'(0), q_item.diff,
                         FRACTION_BITS'(0)};
            step_nxt  = '0;
            state_nxt = ST_DEV;
          end else begin
            fin = 1'b1;
          end
        end
      end
      ST_DEV: begin
        if (div_done) begin
          sum_v   = sat_add(sum_r, sat_dev(q_fin));
          sum_nxt = sum_v;
          fin     = 1'b1;
        end
      end
      ST_MEAN: begin
        if (div_done) begin
          mean_nxt  = sat_dev(q_fin);
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          oq_nxt    = (mean_r > threshold);
          om_nxt    = mean_r;
          oc_nxt    = cnt_r;
          sum_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fin) begin
      if (last_v) begin
        if (cnt_v != '0) begin
          dvs_nxt   = {(VALUE_BITS - COUNT_BITS)'(0), cnt_v};
          rem_nxt   = '0;
          quo_nxt   = sum_v;
          step_nxt  = '0;
          state_nxt = ST_MEAN;
        end else begin
          mean_nxt  = '0;
          state_nxt = ST_OUT;
        end
      end else begin
        state_nxt = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sum_r   <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    dvs_r  <= dvs_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
    mean_r <= mean_nxt;
    oq_r   <= oq_nxt;
    om_r   <= om_nxt;
    oc_r   <= oc_nxt;
  end

endmodule

[test/tb_histogram_mean_relative_deviation_unit.sv]
`timescale 1ns / 100ps
// Self-checking testbench for histogram_mean_relative_deviation_unit: a scoreboard
// class predicts each histogram verdict; tasks drive bins and register writes.
// Depends on hmrd_pkg, the hmrd interfaces and the unit itself.
module tb_histogram_mean_relative_deviation_unit;
  import hmrd_pkg::*;

  typedef struct {
    logic signed [VALUE_BITS-1:0] bin_value;
    logic signed [VALUE_BITS-1:0] reference_value;
    logic [IDX_BITS-1:0]          bin_x;
    logic [IDX_BITS-1:0]          bin_y;
    logic                         last_bin;
  } bin_t;

  typedef struct {
    logic                  quality;
    logic [DEV_BITS-1:0]   mean_deviation;
    logic [COUNT_BITS-1:0] bins_counted;
  } verdict_t;

  class hmrd_scoreboard;
    logic [DEV_BITS-1:0]   threshold;
    hmrd_win_t             win;
    logic [SUM_BITS-1:0]   dev_sum;
    logic [COUNT_BITS-1:0] bin_count;
    verdict_t              verdict_q[$];
    int                    errors;

    function new();
      threshold = DEV_BITS'(65536);
      win = '{x_first: '0, x_last: '1, y_first: '0, y_last: '1};
      dev_sum = '0;
      bin_count = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_THRESHOLD:   threshold = data[DEV_BITS-1:0];
        REG_X_FIRST_BIN: win.x_first = data[IDX_BITS-1:0];
        REG_X_LAST_BIN:  win.x_last = data[IDX_BITS-1:0];
        REG_Y_FIRST_BIN: win.y_first = data[IDX_BITS-1:0];
        REG_Y_LAST_BIN:  win.y_last = data[IDX_BITS-1:0];
        default: ;
      endcase
    endfunction

    // |meas - reference| / |reference| in Q16.16, truncated, saturated
    function logic [DEV_BITS-1:0] bin_deviation(logic signed [VALUE_BITS-1:0] meas,
                                                logic signed [VALUE_BITS-1:0] reference);
      logic signed [63:0] d;
      logic signed [63:0] a;
      logic [63:0]        diff;
      logic [63:0]        mag;
      logic [63:0]        q;
      d = 64'(meas);
      a = 64'(reference);
      d = d - a;
      if (d < 0) d = -d;
      if (a < 0) a = -a;
      diff = d;
      mag = a;
      if (mag == 0) return '0;
      q = (diff << FRACTION_BITS) / mag;
      return (q > 64'hFFFF_FFFF) ? '1 : q[DEV_BITS-1:0];
    endfunction

    function void note_bin(bin_t b);
      logic                in_win;
      logic [SUM_BITS:0]   s;
      logic [SUM_BITS-1:0] m;
      verdict_t            v;
      in_win = b.bin_x >= win.x_first && b.bin_x <= win.x_last &&
               b.bin_y >= win.y_first && b.bin_y <= win.y_last;
      if (in_win && bin_count < MAX_BINS) begin
        s = {1'b0, dev_sum} + {(SUM_BITS - DEV_BITS + 1)'(0),
                               bin_deviation(b.bin_value, b.reference_value)};
        dev_sum = s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
        bin_count++;
      end
      if (b.last_bin) begin
        m = (bin_count != 0) ? dev_sum / SUM_BITS'(bin_count) : '0;
        v.mean_deviation = (m > 52'hFFFF_FFFF) ? '1 : m[DEV_BITS-1:0];
        v.quality = v.mean_deviation > threshold;
        v.bins_counted = bin_count;
        verdict_q.push_back(v);
        dev_sum = '0;
        bin_count = '0;
      end
    endfunction

    function void check_result(verdict_t got);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction: quality %0d mean %h bins %0d",
                 $time, got.quality, got.mean_deviation, got.bins_counted);
        return;
      end
      want = verdict_q.pop_front();
      if (got.quality !== want.quality) begin
        errors++;
        $display("%0t: quality expected %0d actual %0d", $time, want.quality, got.quality);
      end
      if (got.mean_deviation !== want.mean_deviation) begin
        errors++;
        $display("%0t: mean_deviation expected %h actual %h",
                 $time, want.mean_deviation, got.mean_deviation);
      end
      if (got.bins_counted !== want.bins_counted) begin
        errors++;
        $display("%0t: bins_counted expected %0d actual %0d",
                 $time, want.bins_counted, got.bins_counted);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   in_idle_pct;
  int   out_stall_pct;

  hmrd_scoreboard sb;

  hmrd_in_if  in_ch ();
  hmrd_out_if out_ch ();
  hmrd_cfg_if cfg_ch ();

  histogram_mean_relative_deviation_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    verdict_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.quality = out_ch.quality;
      got.mean_deviation = out_ch.mean_deviation;
      got.bins_counted = out_ch.bins_counted;
      sb.check_result(got);
    end
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  task automatic send_bin(bin_t b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.bin_value       <= b.bin_value;
    in_ch.reference_value <= b.reference_value;
    in_ch.bin_x           <= b.bin_x;
    in_ch.bin_y           <= b.bin_y;
    in_ch.last_bin        <= b.last_bin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_bin(b);
  endtask

  task automatic send_fixed(logic signed [31:0] v, logic signed [31:0] r,
                            int x, int y, bit last);
    bin_t b;
    b = '{v, r, IDX_BITS'(x), IDX_BITS'(y), last};
    send_bin(b);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.verdict_q.size() != 0) @(posedge clk);
  endtask

  // only while idle: all verdicts in, then let the back end settle
  task automatic program_regs(logic [31:0] thr, hmrd_win_t w);
    logic [31:0] junk;
    drain();
    repeat (120) @(posedge clk);
    junk = $urandom & ~32'h3FF;
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_X_FIRST_BIN, junk | 32'(w.x_first));
    write_reg(REG_X_LAST_BIN, junk | 32'(w.x_last));
    write_reg(REG_Y_FIRST_BIN, junk | 32'(w.y_first));
    write_reg(REG_Y_LAST_BIN, junk | 32'(w.y_last));
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(5))
      0: begin
        case ($urandom_range(4))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return -32'sd1;
          3: return 32'sd1;
          default: return 32'sd0;
        endcase
      end
      1, 2: return $signed(32'($urandom_range(2000))) - 32'sd1000;
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic logic [2*IDX_BITS-1:0] rand_span();
    logic [IDX_BITS-1:0] a;
    logic [IDX_BITS-1:0] b;
    a = IDX_BITS'($urandom);
    b = IDX_BITS'($urandom);
    case ($urandom_range(7))
      0: return {10'd0, 10'd1023};
      1: return (a == b) ? {10'd1023, 10'd0} : ((a > b) ? {a, b} : {b, a});
      2: return {a, a};
      default: return (a > b) ? {b, a} : {a, b};
    endcase
  endfunction

  function automatic logic [IDX_BITS-1:0] rand_index(logic [IDX_BITS-1:0] first,
                                                    logic [IDX_BITS-1:0] last);
    if (first <= last && $urandom_range(9) < 8) return IDX_BITS'($urandom_range(last, first));
    return IDX_BITS'($urandom);
  endfunction

  function automatic bin_t make_bin(bit last);
    bin_t b;
    b.reference_value = rand_value();
    case ($urandom_range(3))
      0: b.bin_value = b.reference_value;
      1: b.bin_value = b.reference_value + ($signed($urandom) >>> $urandom_range(31, 8));
      default: b.bin_value = rand_value();
    endcase
    b.bin_x = rand_index(sb.win.x_first, sb.win.x_last);
    b.bin_y = rand_index(sb.win.y_first, sb.win.y_last);
    b.last_bin = last;
    return b;
  endfunction

  task automatic random_settings();
    logic [31:0] thr;
    hmrd_win_t   w;
    case ($urandom_range(5))
      0: thr = '0;
      1: thr = '1;
      2: thr = $urandom;
      default: thr = $urandom_range(32'h30000);
    endcase
    {w.x_first, w.x_last} = rand_span();
    {w.y_first, w.y_last} = rand_span();
    program_regs(thr, w);
  endtask

  initial begin
    int sent;
    int n;
    sb = new();
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.bin_value       <= '0;
    in_ch.reference_value <= '0;
    in_ch.bin_x           <= '0;
    in_ch.bin_y           <= '0;
    in_ch.last_bin        <= 1'b0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= '0;
    cfg_ch.data   <= '0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults: full window, threshold 1.0
    send_fixed(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0);
    send_fixed(32'sh8000_0000, 32'sd1, 1023, 1023, 0);
    send_fixed(32'sd5, 32'sd0, 0, 1023, 0);
    send_fixed(-32'sd3, -32'sd4, 1023, 0, 1);
    send_fixed(32'sd200, 32'sd100, 5, 5, 1);
    send_fixed(32'sd300, 32'sd100, 6, 6, 1);
    send_fixed(-32'sd1, -32'sd1, 7, 7, 1);
    send_fixed(32'sd0, 32'sd0, 8, 8, 1);

    program_regs('0, '{x_first: 10'd1000, x_last: 10'd1023, y_first: 10'd3, y_last: 10'd3});
    send_fixed(32'sd10, 32'sd3, 1000, 3, 0);
    send_fixed(32'sd10, 32'sd3, 999, 3, 0);
    send_fixed(32'sd10, 32'sd3, 1023, 4, 0);
    send_fixed(32'sd7, 32'sd7, 1023, 3, 1);
    send_fixed(32'sd1, 32'sd2, 0, 0, 1);

    program_regs('1, '{x_first: 10'd600, x_last: 10'd599, y_first: 10'd0, y_last: 10'd1023});
    send_fixed(32'sh8000_0000, 32'sd1, 600, 0, 0);
    send_fixed(32'sh8000_0000, 32'sd1, 599, 5, 1);

    program_regs('1, '{x_first: 10'd0, x_last: 10'd1023, y_first: 10'd0, y_last: 10'd1023});
    send_fixed(32'sh8000_0000, 32'sd1, 1, 1, 1);

    // three saturated deviations in the sum, then zero references
    program_regs(32'h10000, '{x_first: 10'd0, x_last: 10'd1023, y_first: 10'd0,
                              y_last: 10'd1023});
    for (int i = 0; i < 8; i++) begin
      if (i < 3) send_fixed(32'sh7FFF_FFFF, 32'sd1, i, i, 0);
      else send_fixed($signed($urandom), 32'sd0, i, 1023 - i, i == 7);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 69; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 69; end
        default: begin in_idle_pct = 14; out_stall_pct = 14; end
      endcase
      for (int s = 0; s < 3; s++) begin
        random_settings();
        sent = 0;
        while (sent < 34) begin
          n = $urandom_range(12, 1);
          for (int i = 0; i < n; i++) send_bin(make_bin(i == n - 1));
          sent += n;
        end
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

[files.f]
design/hmrd_pkg.sv
design/hmrd_if.sv
design/hmrd_front.sv
design/hmrd_queue.sv
design/hmrd_back.sv
design/histogram_mean_relative_deviation_unit.sv
test/tb_histogram_mean_relative_deviation_unit.sv
